// ===== rtl/core/ebc_pkg.sv =====
// Package for the environment block checker: sizes, item kind and status codes,
// configuration register indexes, shared structs and the bytewise CRC-32 update.
// Depends on nothing; every other file of the block refers to it by scoped names.
package ebc_pkg;

    // Block geometry.
    localparam int BLOCK_BYTES = 512;
    localparam int MAX_BLOCKS  = 128;
    localparam int POS_W       = $clog2(MAX_BLOCKS * BLOCK_BYTES);
    localparam int LEN_W       = POS_W + 1;

    // Header layout.
    localparam int HDR_BYTES    = 4;
    localparam int DATA_OFF_STD = 4;
    localparam int DATA_OFF_RED = 5;

    // Field widths.
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int CRC_W      = 32;
    localparam int BLK_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Byte kinds.
    localparam logic [KIND_W-1:0] KIND_HEADER   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FLAG     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NAME     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EQUALS   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_VALUE    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PAIR_END = 3'd5;
    localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd6;

    // Final status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CRC_BAD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FORMAT  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUNDANT  = 1'b1;

    // Special byte values.
    localparam logic [BYTE_W-1:0] CHAR_EQUALS = 8'h3D;
    localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;

    // CRC-32, reflected form.
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

    // Configuration as seen by the front end.
    typedef struct packed {
        logic [BLK_W-1:0] num_blocks;
        logic             redundant;
    } t_cfg;

    // One classified item travelling from the front end to the back end.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [KIND_W-1:0] kind;
        logic              is_data;
        logic              done;
        logic              bad_format;
        logic [CRC_W-1:0]  header_crc;
    } t_q_item;

    // One byte step of the reflected CRC-32.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/ebc_in_if.sv =====
// Input channel of the environment block checker: valid, ready and one data byte.
// Depends on ebc_pkg for the field width.
interface ebc_in_if;
    logic                          valid;
    logic                          ready;
    logic [ebc_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/core/ebc_out_if.sv =====
// Output channel of the environment block checker: valid, ready and the result fields.
// Depends on ebc_pkg for the field widths.
interface ebc_out_if;
    logic                          valid;
    logic                          ready;
    logic [ebc_pkg::BYTE_W-1:0]    out_byte;
    logic [ebc_pkg::KIND_W-1:0]    byte_kind;
    logic                          block_done;
    logic [ebc_pkg::STATUS_W-1:0]  status;
    logic [ebc_pkg::CRC_W-1:0]     stored_crc;
    logic [ebc_pkg::CRC_W-1:0]     computed_crc;

    modport source (output valid, output out_byte, output byte_kind, output block_done,
                    output status, output stored_crc, output computed_crc, input ready);
    modport sink   (input valid, input out_byte, input byte_kind, input block_done,
                    input status, input stored_crc, input computed_crc, output ready);
endinterface

// ===== rtl/core/ebc_front.sv =====
// Front end: accepts bytes, tracks the block position and the name/value parser,
// tags each item and pushes it into the queue. Depends on ebc_pkg and ebc_in_if.
module ebc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ebc_pkg::t_cfg     i_cfg,
    ebc_in_if.sink            i_in,
    input  logic              i_q_ready,
    output logic              o_push,
    output ebc_pkg::t_q_item  o_item
);

    // Parser phases.
    localparam logic [1:0] PH_NAME_START = 2'd0;
    localparam logic [1:0] PH_NAME       = 2'd1;
    localparam logic [1:0] PH_VALUE      = 2'd2;

    logic [ebc_pkg::POS_W-1:0] r_pos;
    logic [1:0]                r_phase;
    logic                      r_fmt_err;
    logic                      r_list_end;
    logic [ebc_pkg::CRC_W-1:0] r_hdr;

    logic [ebc_pkg::POS_W-1:0]  n_pos;
    logic [1:0]                 n_phase;
    logic                       n_fmt_err;
    logic                       n_list_end;
    logic [ebc_pkg::CRC_W-1:0]  n_hdr;

    logic [ebc_pkg::BYTE_W-1:0] b;
    logic [ebc_pkg::LEN_W-1:0]  blocks;
    logic [ebc_pkg::LEN_W-1:0]  len;
    logic [ebc_pkg::POS_W-1:0]  last_pos;
    logic [ebc_pkg::POS_W-1:0]  data_off;
    logic                       is_hdr;
    logic                       is_flag;
    logic                       done;
    logic [ebc_pkg::KIND_W-1:0] kind;
    logic                       accept;

    assign b          = i_in.data_byte;
    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;
    assign o_push     = accept;

    // Clamp the block count and find the position of the last byte.
    always_comb begin
        if (i_cfg.num_blocks == '0) begin
            blocks = ebc_pkg::LEN_W'(1);
        end else if (int'(i_cfg.num_blocks) > ebc_pkg::MAX_BLOCKS) begin
            blocks = ebc_pkg::LEN_W'(ebc_pkg::MAX_BLOCKS);
        end else begin
            blocks = ebc_pkg::LEN_W'(i_cfg.num_blocks);
        end
        len      = blocks * ebc_pkg::LEN_W'(ebc_pkg::BLOCK_BYTES);
        last_pos = ebc_pkg::POS_W'(len - ebc_pkg::LEN_W'(1));
        data_off = i_cfg.redundant ? ebc_pkg::POS_W'(ebc_pkg::DATA_OFF_RED)
                                   : ebc_pkg::POS_W'(ebc_pkg::DATA_OFF_STD);
    end

    assign is_hdr  = r_pos < ebc_pkg::POS_W'(ebc_pkg::HDR_BYTES);
    assign is_flag = !is_hdr && (r_pos < data_off);
    assign done    = r_pos >= last_pos;

    // Classify the byte and work out the next parser state.
    always_comb begin
        n_phase    = r_phase;
        n_fmt_err  = r_fmt_err;
        n_list_end = r_list_end;
        n_hdr      = r_hdr;
        kind       = ebc_pkg::KIND_IGNORED;
        if (is_hdr) begin
            kind  = ebc_pkg::KIND_HEADER;
            n_hdr = r_hdr | (ebc_pkg::CRC_W'(b) << {r_pos[1:0], 3'b000});
        end else if (is_flag) begin
            kind = ebc_pkg::KIND_FLAG;
        end else if (r_fmt_err || r_list_end) begin
            kind = ebc_pkg::KIND_IGNORED;
        end else begin
            case (r_phase)
                PH_NAME_START: begin
                    if (b == ebc_pkg::CHAR_NUL) begin
                        kind       = ebc_pkg::KIND_PAIR_END;
                        n_list_end = 1'b1;
                    end else begin
                        kind    = ebc_pkg::KIND_NAME;
                        n_phase = PH_NAME;
                    end
                end
                PH_NAME: begin
                    if (b == ebc_pkg::CHAR_NUL) begin
                        kind      = ebc_pkg::KIND_IGNORED;
                        n_fmt_err = 1'b1;
                    end else if (b == ebc_pkg::CHAR_EQUALS) begin
                        kind    = ebc_pkg::KIND_EQUALS;
                        n_phase = PH_VALUE;
                    end else begin
                        kind = ebc_pkg::KIND_NAME;
                    end
                end
                default: begin
                    if (b == ebc_pkg::CHAR_NUL) begin
                        kind    = ebc_pkg::KIND_PAIR_END;
                        n_phase = PH_NAME_START;
                    end else begin
                        kind = ebc_pkg::KIND_VALUE;
                    end
                end
            endcase
        end
        n_pos = r_pos + ebc_pkg::POS_W'(1);
    end

    // Item handed to the back end.
    always_comb begin
        o_item.data_byte  = b;
        o_item.kind       = kind;
        o_item.is_data    = !is_hdr && !is_flag;
        o_item.done       = done;
        o_item.bad_format = n_fmt_err || (!n_list_end && (n_phase != PH_NAME_START));
        o_item.header_crc = n_hdr;
    end

    // Parser state; everything returns to its reset value after the last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_phase    <= PH_NAME_START;
            r_fmt_err  <= 1'b0;
            r_list_end <= 1'b0;
            r_hdr      <= '0;
        end else if (accept) begin
            if (done) begin
                r_pos      <= '0;
                r_phase    <= PH_NAME_START;
                r_fmt_err  <= 1'b0;
                r_list_end <= 1'b0;
                r_hdr      <= '0;
            end else begin
                r_pos      <= n_pos;
                r_phase    <= n_phase;
                r_fmt_err  <= n_fmt_err;
                r_list_end <= n_list_end;
                r_hdr      <= n_hdr;
            end
        end
    end

    // A format error and the list end exclude each other.
    a_err_xor_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fmt_err && r_list_end))
        else $error("format error and list end both set");

    // Each accepted byte that does not end the block advances the position by one.
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !done) |=> (r_pos == $past(r_pos) + ebc_pkg::POS_W'(1)))
        else $error("position did not advance");

endmodule

// ===== rtl/core/ebc_queue.sv =====
// Two-entry queue between the front end and the back end, so each side stalls on its own.
// Depends on ebc_pkg for the item struct.
module ebc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ebc_pkg::t_q_item  i_item,
    output logic              o_ready,
    output logic              o_valid,
    output ebc_pkg::t_q_item  o_item,
    input  logic              i_pop
);

    ebc_pkg::t_q_item r_slot [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;

    assign o_ready = r_count != 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_item  = r_slot[r_rd];

    // Item storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // The fill count never passes the depth and never underflows.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= 2'd2) && !(i_pop && r_count == 2'd0))
        else $error("queue fill count out of range");

endmodule

// ===== rtl/core/ebc_back.sv =====
// Back end: runs the CRC-32 over the data bytes, forms the final status and holds
// each result item in an output register. Depends on ebc_pkg and ebc_out_if.
module ebc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  ebc_pkg::t_q_item  i_item,
    output logic              o_pop,
    ebc_out_if.source         o_out
);

    logic [ebc_pkg::CRC_W-1:0]    r_crc;
    logic                         r_valid;
    logic [ebc_pkg::BYTE_W-1:0]   r_byte;
    logic [ebc_pkg::KIND_W-1:0]   r_kind;
    logic                         r_done;
    logic [ebc_pkg::STATUS_W-1:0] r_status;
    logic [ebc_pkg::CRC_W-1:0]    r_stored;
    logic [ebc_pkg::CRC_W-1:0]    r_computed;

    logic [ebc_pkg::CRC_W-1:0]    n_crc;
    logic [ebc_pkg::CRC_W-1:0]    computed;
    logic [ebc_pkg::STATUS_W-1:0] status;

    assign o_pop = i_q_valid && (!r_valid || o_out.ready);

    // CRC update and status decision for the item at the head of the queue.
    always_comb begin
        n_crc    = i_item.is_data ? ebc_pkg::crc_byte(r_crc, i_item.data_byte) : r_crc;
        computed = ~n_crc;
        if (computed != i_item.header_crc) begin
            status = ebc_pkg::ST_CRC_BAD;
        end else if (i_item.bad_format) begin
            status = ebc_pkg::ST_FORMAT;
        end else begin
            status = ebc_pkg::ST_OK;
        end
    end

    // Running CRC; it restarts after the last byte of a block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= ebc_pkg::CRC_INIT;
        end else if (o_pop) begin
            r_crc <= i_item.done ? ebc_pkg::CRC_INIT : n_crc;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output register payload; the report fields are zero except on the last byte.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte     <= i_item.data_byte;
            r_kind     <= i_item.kind;
            r_done     <= i_item.done;
            r_status   <= i_item.done ? status : ebc_pkg::ST_OK;
            r_stored   <= i_item.done ? i_item.header_crc : '0;
            r_computed <= i_item.done ? computed : '0;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_byte     = r_byte;
    assign o_out.byte_kind    = r_kind;
    assign o_out.block_done   = r_done;
    assign o_out.status       = r_status;
    assign o_out.stored_crc   = r_stored;
    assign o_out.computed_crc = r_computed;

    // After the last byte of a block the CRC starts again from all ones.
    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.done) |=> (r_crc == ebc_pkg::CRC_INIT))
        else $error("CRC not restarted after block end");

endmodule

// ===== rtl/core/env_block_checker_unit.sv =====
// Top level of the environment block checker: configuration registers and the
// front end, queue and back end. Depends on ebc_pkg, ebc_in_if, ebc_out_if and the submodules.
//
// The checker takes one byte of an environment block per clock cycle while the queue
// has room, and returns one result item per byte. An accepted byte is written into the
// queue, then popped into the output register, which offers its result item on the
// output; new bytes can be accepted while earlier ones are in flight. The front end
// classifies each byte against the position and the name/value parser state in the
// cycle it is accepted; the back end applies a bytewise CRC-32 update and holds the
// result in an output register. A two-entry queue lets either side stall without
// stopping the other; together with the output register it holds three items, and the
// input stalls only once all three are waiting. The last byte of a block of the
// configured number of 512-byte blocks carries the status, the stored CRC and the
// computed CRC; the next byte starts a new block. The user must write configuration
// only while no items are in flight; the block itself does not enforce it.
module env_block_checker_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ebc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ebc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ebc_in_if.sink                            i_in,
    ebc_out_if.source                         o_out
);

    logic [ebc_pkg::BLK_W-1:0] r_num_blocks;
    logic                      r_redundant;

    ebc_pkg::t_cfg    cfg;
    ebc_pkg::t_q_item front_item;
    ebc_pkg::t_q_item queue_item;
    logic             push;
    logic             q_ready;
    logic             q_valid;
    logic             pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_blocks <= ebc_pkg::BLK_W'(1);
            r_redundant  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ebc_pkg::CFG_NUM_BLOCKS: r_num_blocks <= i_cfg_data[ebc_pkg::BLK_W-1:0];
                ebc_pkg::CFG_REDUNDANT:  r_redundant  <= i_cfg_data[0];
                default:                 r_redundant  <= r_redundant;
            endcase
        end
    end

    assign cfg.num_blocks = r_num_blocks;
    assign cfg.redundant  = r_redundant;

    ebc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_item    (front_item)
    );

    ebc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (queue_item),
        .i_pop   (pop)
    );

    ebc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (queue_item),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
